@@ src/rtid_pkg.sv @@
package rtid_pkg;

    // coordinate formats
    localparam int CW     = 21;           // packed coordinate width
    localparam int EW     = CW + 1;       // edge and offset vectors
    localparam int PW     = 2 * EW;       // cross product partial terms
    localparam int XW     = PW + 1;       // cross product results
    localparam int DPW    = XW + EW;      // dot product partial terms
    localparam int WW     = DPW + 3;      // determinant and numerators
    localparam int RW     = WW + 1;       // divider partial remainder
    localparam int QW     = 32;           // quotient bits per division
    localparam int FRAC_Q = 16;           // Q1.16 weights and Q16.16 distance
    localparam int BW     = FRAC_Q + 1;   // barycentric weight width
    localparam int MW     = BW + 1 + EW;  // weight times edge
    localparam int AW     = MW + 2;       // hit point accumulator
    localparam int TW     = 32;           // distance width
    localparam int EPSW   = 31;           // epsilon width
    localparam int PRW    = 2 * TW;       // epsilon product width

    localparam logic signed [TW-1:0] T_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TW-1:0] T_MIN = 32'sh8000_0000;

    // |t| / 1000 as (|t| * ceil(2^41 / 1000)) >> 41, exact for |t| <= 2^31
    localparam logic [TW-1:0] EPS_RECIP = 32'd2199023256;
    localparam int            EPS_SHIFT = 41;

    localparam logic signed [AW-1:0] ROUND_HALF = AW'(32768);

    typedef logic [3*CW-1:0]       vtx_t;
    typedef logic signed [CW-1:0]  coord_t;
    typedef logic signed [EW-1:0]  edge_t;
    typedef logic signed [WW-1:0]  wide_t;

    typedef struct packed {
        vtx_t                  vertex_zero;
        vtx_t                  vertex_one;
        vtx_t                  vertex_two;
        vtx_t                  ray_origin;
        vtx_t                  ray_direction;
        logic signed [TW-1:0]  t_lower;
        logic signed [TW-1:0]  t_upper;
    } in_t;

    typedef struct packed {
        logic                  hit;
        logic signed [TW-1:0]  distance;
        logic [BW-1:0]         bary_first;
        logic [BW-1:0]         bary_second;
        vtx_t                  hit_point;
        logic [EPSW-1:0]       ray_offset;
    } out_t;

    // data that rides along the divider
    typedef struct packed {
        coord_t [2:0]          p0;
        edge_t  [2:0]          e1;
        edge_t  [2:0]          e2;
        logic signed [TW-1:0]  tl;
        logic signed [TW-1:0]  tu;
        logic                  tneg;
        logic                  miss;
    } side_t;

    // lane 0: |nt|, lane 1: n1, lane 2: n2
    typedef struct packed {
        logic [2:0][WW-1:0]    num;
        logic [WW-1:0]         den;
        side_t                 side;
    } div_in_t;

    typedef struct packed {
        logic [2:0][QW-1:0]    q;
        logic [2:0]            ovf;
        side_t                 side;
    } div_out_t;

    function automatic coord_t coord_of(vtx_t word, int k);
        return word[k*CW +: CW];
    endfunction

endpackage

@@ src/rtid_front.sv @@
module rtid_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  rtid_pkg::in_t     in_data,
    output logic              out_valid,
    output rtid_pkg::div_in_t out_data
);
    import rtid_pkg::*;

    localparam int NS = 7;

    logic [NS-1:0] vld_reg, vld_next;

    // stage 1: unpack and edges
    coord_t [2:0] p0_1_reg, p0_1_next, dir_1_reg, dir_1_next;
    edge_t  [2:0] e1_1_reg, e1_1_next, e2_1_reg, e2_1_next, s_1_reg, s_1_next;
    logic signed [TW-1:0] tl_1_reg, tu_1_reg;

    // stage 2: cross product terms
    logic signed [2:0][PW-1:0] pa1_reg, pa1_next, pb1_reg, pb1_next;
    logic signed [2:0][PW-1:0] pa2_reg, pa2_next, pb2_reg, pb2_next;
    coord_t [2:0] p0_2_reg, dir_2_reg;
    edge_t  [2:0] e1_2_reg, e2_2_reg, s_2_reg;
    logic signed [TW-1:0] tl_2_reg, tu_2_reg;

    // stage 3: cross products
    logic signed [2:0][XW-1:0] cr1_reg, cr1_next, cr2_reg, cr2_next;
    coord_t [2:0] p0_3_reg, dir_3_reg;
    edge_t  [2:0] e1_3_reg, e2_3_reg, s_3_reg;
    logic signed [TW-1:0] tl_3_reg, tu_3_reg;

    // stage 4: dot product terms, index 0 det, 1 n1, 2 n2, 3 nt
    logic signed [3:0][2:0][DPW-1:0] dp_reg, dp_next;
    coord_t [2:0] p0_4_reg;
    edge_t  [2:0] e1_4_reg, e2_4_reg;
    logic signed [TW-1:0] tl_4_reg, tu_4_reg;

    // stage 5: sums
    logic signed [3:0][WW-1:0] sum_reg, sum_next;
    coord_t [2:0] p0_5_reg;
    edge_t  [2:0] e1_5_reg, e2_5_reg;
    logic signed [TW-1:0] tl_5_reg, tu_5_reg;

    // stage 6: orientation fix
    logic signed [3:0][WW-1:0] fix_reg, fix_next;
    logic zero_6_reg, zero_6_next;
    coord_t [2:0] p0_6_reg;
    edge_t  [2:0] e1_6_reg, e2_6_reg;
    logic signed [TW-1:0] tl_6_reg, tu_6_reg;

    // stage 7: miss tests and divider operands
    div_in_t div_reg, div_next;

    assign vld_next = {vld_reg[NS-2:0], in_valid};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p0_1_next[k]  = coord_of(in_data.vertex_zero, k);
            dir_1_next[k] = coord_of(in_data.ray_direction, k);
            e1_1_next[k]  = EW'(coord_of(in_data.vertex_one, k)) - EW'(p0_1_next[k]);
            e2_1_next[k]  = EW'(coord_of(in_data.vertex_two, k)) - EW'(p0_1_next[k]);
            s_1_next[k]   = EW'(coord_of(in_data.ray_origin, k)) - EW'(p0_1_next[k]);
        end
    end

    always_comb
    begin
        int j1;
        int j2;
        for (int k = 0; k < 3; k++)
        begin
            j1 = (k == 2) ? 0 : k + 1;
            j2 = (k == 0) ? 2 : k - 1;
            pa1_next[k] = PW'(dir_1_reg[j1]) * PW'(e2_1_reg[j2]);
            pb1_next[k] = PW'(dir_1_reg[j2]) * PW'(e2_1_reg[j1]);
            pa2_next[k] = PW'(s_1_reg[j1]) * PW'(e1_1_reg[j2]);
            pb2_next[k] = PW'(s_1_reg[j2]) * PW'(e1_1_reg[j1]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cr1_next[k] = XW'($signed(pa1_reg[k])) - XW'($signed(pb1_reg[k]));
            cr2_next[k] = XW'($signed(pa2_reg[k])) - XW'($signed(pb2_reg[k]));
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dp_next[0][k] = DPW'($signed(cr1_reg[k])) * DPW'(e1_3_reg[k]);
            dp_next[1][k] = DPW'($signed(cr1_reg[k])) * DPW'(s_3_reg[k]);
            dp_next[2][k] = DPW'($signed(cr2_reg[k])) * DPW'(dir_3_reg[k]);
            dp_next[3][k] = DPW'($signed(cr2_reg[k])) * DPW'(e2_3_reg[k]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sum_next[i] = WW'($signed(dp_reg[i][0])) + WW'($signed(dp_reg[i][1]))
                        + WW'($signed(dp_reg[i][2]));
        end
    end

    // negative determinant: negate everything so both windings hit
    always_comb
    begin
        zero_6_next = (sum_reg[0] == '0);
        for (int i = 0; i < 4; i++)
        begin
            fix_next[i] = sum_reg[0][WW-1] ? -$signed(sum_reg[i]) : $signed(sum_reg[i]);
        end
    end

    always_comb
    begin
        wide_t            det;
        wide_t            n1;
        wide_t            n2;
        wide_t            nt;
        logic signed [WW:0] n12;
        det = fix_reg[0];
        n1  = fix_reg[1];
        n2  = fix_reg[2];
        nt  = fix_reg[3];
        n12 = (WW+1)'(n1) + (WW+1)'(n2);
        div_next.side.p0   = p0_6_reg;
        div_next.side.e1   = e1_6_reg;
        div_next.side.e2   = e2_6_reg;
        div_next.side.tl   = tl_6_reg;
        div_next.side.tu   = tu_6_reg;
        div_next.side.tneg = nt[WW-1];
        div_next.side.miss = zero_6_reg || n1[WW-1] || (n1 > det) || n2[WW-1]
                             || (n12 > (WW+1)'(det));
        div_next.num[0]    = nt[WW-1] ? WW'(-nt) : WW'(nt);
        div_next.num[1]    = WW'(n1);
        div_next.num[2]    = WW'(n2);
        div_next.den       = WW'(det);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_1_reg  <= p0_1_next;
            dir_1_reg <= dir_1_next;
            e1_1_reg  <= e1_1_next;
            e2_1_reg  <= e2_1_next;
            s_1_reg   <= s_1_next;
            tl_1_reg  <= in_data.t_lower;
            tu_1_reg  <= in_data.t_upper;

            pa1_reg   <= pa1_next;
            pb1_reg   <= pb1_next;
            pa2_reg   <= pa2_next;
            pb2_reg   <= pb2_next;
            p0_2_reg  <= p0_1_reg;
            dir_2_reg <= dir_1_reg;
            e1_2_reg  <= e1_1_reg;
            e2_2_reg  <= e2_1_reg;
            s_2_reg   <= s_1_reg;
            tl_2_reg  <= tl_1_reg;
            tu_2_reg  <= tu_1_reg;

            cr1_reg   <= cr1_next;
            cr2_reg   <= cr2_next;
            p0_3_reg  <= p0_2_reg;
            dir_3_reg <= dir_2_reg;
            e1_3_reg  <= e1_2_reg;
            e2_3_reg  <= e2_2_reg;
            s_3_reg   <= s_2_reg;
            tl_3_reg  <= tl_2_reg;
            tu_3_reg  <= tu_2_reg;

            dp_reg    <= dp_next;
            p0_4_reg  <= p0_3_reg;
            e1_4_reg  <= e1_3_reg;
            e2_4_reg  <= e2_3_reg;
            tl_4_reg  <= tl_3_reg;
            tu_4_reg  <= tu_3_reg;

            sum_reg   <= sum_next;
            p0_5_reg  <= p0_4_reg;
            e1_5_reg  <= e1_4_reg;
            e2_5_reg  <= e2_4_reg;
            tl_5_reg  <= tl_4_reg;
            tu_5_reg  <= tu_4_reg;

            fix_reg    <= fix_next;
            zero_6_reg <= zero_6_next;
            p0_6_reg   <= p0_5_reg;
            e1_6_reg   <= e1_5_reg;
            e2_6_reg   <= e2_5_reg;
            tl_6_reg   <= tl_5_reg;
            tu_6_reg   <= tu_5_reg;

            div_reg   <= div_next;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_data  = div_reg;

endmodule

@@ src/rtid_div.sv @@
module rtid_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rtid_pkg::div_in_t  in_data,
    output logic               out_valid,
    output rtid_pkg::div_out_t out_data
);
    import rtid_pkg::*;

    typedef struct packed {
        logic [2:0][RW-1:0]     rem;
        logic [2:0][QW-1:0]     q;
        logic [2:0]             ovf;
        logic [2:0][FRAC_Q-1:0] nlo;
        logic [WW-1:0]          den;
        side_t                  side;
    } divst_t;

    divst_t     st_reg  [0:QW];
    divst_t     st_next [0:QW];
    logic [QW:0] vld_reg, vld_next;

    assign vld_next = {vld_reg[QW-1:0], in_valid};

    always_comb
    begin
        logic [RW-1:0] trial;
        // entry: remainder starts at num >> 16, quotient past 32 bits flags overflow
        st_next[0].den  = in_data.den;
        st_next[0].side = in_data.side;
        for (int i = 0; i < 3; i++)
        begin
            st_next[0].rem[i] = RW'(in_data.num[i][WW-1:FRAC_Q]);
            st_next[0].ovf[i] = (RW'(in_data.num[i][WW-1:FRAC_Q]) >= RW'(in_data.den));
            st_next[0].nlo[i] = in_data.num[i][FRAC_Q-1:0];
            st_next[0].q[i]   = '0;
        end
        // one quotient bit per stage, msb first
        for (int g = 1; g <= QW; g++)
        begin
            st_next[g].den  = st_reg[g-1].den;
            st_next[g].side = st_reg[g-1].side;
            st_next[g].ovf  = st_reg[g-1].ovf;
            for (int i = 0; i < 3; i++)
            begin
                trial = {st_reg[g-1].rem[i][RW-2:0], st_reg[g-1].nlo[i][FRAC_Q-1]};
                st_next[g].nlo[i] = {st_reg[g-1].nlo[i][FRAC_Q-2:0], 1'b0};
                if (trial >= RW'(st_reg[g-1].den))
                begin
                    st_next[g].rem[i] = trial - RW'(st_reg[g-1].den);
                    st_next[g].q[i]   = {st_reg[g-1].q[i][QW-2:0], 1'b1};
                end
                else
                begin
                    st_next[g].rem[i] = trial;
                    st_next[g].q[i]   = {st_reg[g-1].q[i][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g <= QW; g++)
            begin
                st_reg[g] <= st_next[g];
            end
        end
    end

    assign out_valid     = vld_reg[QW];
    assign out_data.q    = st_reg[QW].q;
    assign out_data.ovf  = st_reg[QW].ovf;
    assign out_data.side = st_reg[QW].side;

endmodule

@@ src/rtid_back.sv @@
module rtid_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rtid_pkg::div_out_t in_data,
    output logic               out_valid,
    output rtid_pkg::out_t     out_data
);
    import rtid_pkg::*;

    logic [2:0] vld_reg, vld_next;

    // stage 1: distance, interval test, weight products
    logic signed [TW-1:0]      t1_reg, t1_next;
    logic                      miss1_reg, miss1_next;
    logic [BW-1:0]             b1_1_reg, b2_1_reg;
    logic signed [2:0][MW-1:0] m1_reg, m1_next, m2_reg, m2_next;
    coord_t [2:0]              p0_1_reg;

    // stage 2: hit point sums, epsilon product
    logic signed [TW-1:0]      t2_reg;
    logic                      miss2_reg;
    logic [BW-1:0]             b1_2_reg, b2_2_reg;
    vtx_t                      pt_reg, pt_next;
    logic [PRW-1:0]            eps_reg, eps_next;

    out_t                      res_reg, res_next;

    assign vld_next = {vld_reg[1:0], in_valid};

    always_comb
    begin
        logic                  sat;
        logic signed [TW-1:0]  qs;
        logic signed [BW:0]    w1;
        logic signed [BW:0]    w2;
        sat = in_data.ovf[0] | in_data.q[0][QW-1];
        qs  = $signed(in_data.q[0]);
        if (!in_data.side.tneg)
            t1_next = sat ? T_MAX : qs;
        else
            t1_next = sat ? T_MIN : -qs;
        miss1_next = in_data.side.miss || (t1_next < in_data.side.tl)
                     || (t1_next > in_data.side.tu);
        w1 = $signed({1'b0, in_data.q[1][BW-1:0]});
        w2 = $signed({1'b0, in_data.q[2][BW-1:0]});
        for (int k = 0; k < 3; k++)
        begin
            m1_next[k] = MW'(w1) * MW'(in_data.side.e1[k]);
            m2_next[k] = MW'(w2) * MW'(in_data.side.e2[k]);
        end
    end

    // round half up: floor((65536*p0 + B1*e1 + B2*e2 + 32768) / 65536)
    always_comb
    begin
        logic signed [AW-1:0] acc;
        logic [TW-1:0]        mag;
        for (int k = 0; k < 3; k++)
        begin
            acc = (AW'(p0_1_reg[k]) <<< FRAC_Q) + AW'($signed(m1_reg[k]))
                + AW'($signed(m2_reg[k])) + ROUND_HALF;
            pt_next[k*CW +: CW] = acc[FRAC_Q+CW-1:FRAC_Q];
        end
        mag      = t1_reg[TW-1] ? TW'(-t1_reg) : TW'(t1_reg);
        eps_next = PRW'(mag) * PRW'(EPS_RECIP);
    end

    always_comb
    begin
        res_next = '0;
        if (!miss2_reg)
        begin
            res_next.hit         = 1'b1;
            res_next.distance    = t2_reg;
            res_next.bary_first  = b1_2_reg;
            res_next.bary_second = b2_2_reg;
            res_next.hit_point   = pt_reg;
            res_next.ray_offset  = EPSW'(eps_reg[PRW-1:EPS_SHIFT]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg    <= t1_next;
            miss1_reg <= miss1_next;
            b1_1_reg  <= in_data.q[1][BW-1:0];
            b2_1_reg  <= in_data.q[2][BW-1:0];
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            p0_1_reg  <= in_data.side.p0;

            t2_reg    <= t1_reg;
            miss2_reg <= miss1_reg;
            b1_2_reg  <= b1_1_reg;
            b2_2_reg  <= b2_1_reg;
            pt_reg    <= pt_next;
            eps_reg   <= eps_next;

            res_reg   <= res_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = res_reg;

endmodule

@@ src/ray_triangle_intersection_top.sv @@
// path from an accepted triangle transfer to its result:
// (7 geometry stages, 33 divider stages, 3 finishing stages)
// throughput: one test per cycle; the pipeline moves as a whole and holds
// only while a finished result waits on res_stall
// reset: asynchronous active low, clears all stage valid bits, data is not reset
module ray_triangle_intersection_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tri_valid,
    output logic           tri_stall,
    input  rtid_pkg::in_t  tri_data,
    output logic           res_valid,
    input  logic           res_stall,
    output rtid_pkg::out_t res_data
);
    import rtid_pkg::*;

    // pipeline advance: move unless the output register holds an untaken result
    logic     en;
    logic     front_valid;
    div_in_t  front_data;
    logic     div_valid;
    div_out_t div_data;

    assign en        = !(res_valid && res_stall);
    assign tri_stall = !en;

    // edges, cross products, determinant and numerators, miss tests
    rtid_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tri_valid),
        .in_data   (tri_data),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    // three restoring dividers in lockstep: t, b1, b2
    rtid_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    // saturation, interval test, hit point, epsilon, output register
    rtid_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .out_valid (res_valid),
        .out_data  (res_data)
    );

endmodule

@@ verif/ray_triangle_intersection_top_test.sv @@
module ray_triangle_intersection_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rtid_pkg::*;

    typedef logic signed [127:0] big_t;

    logic clk;
    logic rst_n;
    logic tri_valid;
    logic tri_stall;
    in_t  tri_data;
    logic res_valid;
    logic res_stall;
    out_t res_data;

    // pending triangle/ray pairs and predicted results
    in_t  pending_rays[$];
    out_t expected_results[$];

    int send_idle_pct;
    int stall_pct;
    int mismatches;
    bit hold_request;
    bit hold_done;
    int hold_left;

    ray_triangle_intersection_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_valid (tri_valid),
        .tri_stall (tri_stall),
        .tri_data  (tri_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // clock, 2 ns period
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // signed coordinate k of a packed vertex, widened
    function automatic big_t coord_at(vtx_t word, int k);
        coord_t c;
        c = word[k*CW +: CW];
        return big_t'(c);
    endfunction

    // floor(num * 2^16 / den), capped at 2^32
    function automatic logic [32:0] scaled_quotient(big_t num, big_t den);
        if ((num <<< 16) >= (den <<< 32))
            return 33'h1_0000_0000;
        return 33'((num <<< 16) / den);
    endfunction

    function automatic out_t predict_intersection(in_t it);
        big_t p0[3], p1[3], p2[3], org[3], dir[3];
        big_t e1[3], e2[3], s[3], s1[3], s2[3];
        big_t det, n1, n2, nt, mag, acc, tval, tl, tu;
        logic [32:0] q, w1, w2;
        logic [63:0] abs_t;
        bit tneg;
        out_t r;
        r = '0;
        for (int k = 0; k < 3; k++)
        begin
            p0[k]  = coord_at(it.vertex_zero, k);
            p1[k]  = coord_at(it.vertex_one, k);
            p2[k]  = coord_at(it.vertex_two, k);
            org[k] = coord_at(it.ray_origin, k);
            dir[k] = coord_at(it.ray_direction, k);
            e1[k]  = p1[k] - p0[k];
            e2[k]  = p2[k] - p0[k];
            s[k]   = org[k] - p0[k];
        end
        s1[0] = dir[1] * e2[2] - dir[2] * e2[1];
        s1[1] = dir[2] * e2[0] - dir[0] * e2[2];
        s1[2] = dir[0] * e2[1] - dir[1] * e2[0];
        s2[0] = s[1] * e1[2] - s[2] * e1[1];
        s2[1] = s[2] * e1[0] - s[0] * e1[2];
        s2[2] = s[0] * e1[1] - s[1] * e1[0];
        det = s1[0] * e1[0] + s1[1] * e1[1] + s1[2] * e1[2];
        if (det == 0)
            return r;
        n1 = s1[0] * s[0] + s1[1] * s[1] + s1[2] * s[2];
        n2 = s2[0] * dir[0] + s2[1] * dir[1] + s2[2] * dir[2];
        nt = s2[0] * e2[0] + s2[1] * e2[1] + s2[2] * e2[2];
        // flip orientation so det is positive
        if (det < 0)
        begin
            det = -det;
            n1  = -n1;
            n2  = -n2;
            nt  = -nt;
        end
        if (n1 < 0 || n1 > det)
            return r;
        if (n2 < 0 || n1 + n2 > det)
            return r;
        tneg = nt < 0;
        mag  = tneg ? -nt : nt;
        q    = scaled_quotient(mag, det);
        if (!tneg)
            tval = (q > 33'h7FFF_FFFF) ? big_t'(32'h7FFF_FFFF) : big_t'(q);
        else
            tval = (q >= 33'h8000_0000) ? -big_t'(33'h8000_0000) : -big_t'(q);
        tl = big_t'(it.t_lower);
        tu = big_t'(it.t_upper);
        if (tval < tl || tval > tu)
            return r;
        w1 = scaled_quotient(n1, det);
        w2 = scaled_quotient(n2, det);
        for (int k = 0; k < 3; k++)
        begin
            acc = 65536 * p0[k] + big_t'(w1) * e1[k] + big_t'(w2) * e2[k] + 32768;
            acc = acc >>> 16;
            r.hit_point[k*CW +: CW] = acc[CW-1:0];
        end
        abs_t = (tval < 0) ? 64'(-tval) : 64'(tval);
        r.hit         = 1'b1;
        r.distance    = tval[31:0];
        r.bary_first  = w1[BW-1:0];
        r.bary_second = w2[BW-1:0];
        r.ray_offset  = EPSW'(abs_t / 1000);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic vtx_t pack_vertex(int x, int y, int z);
        logic [31:0] ux, uy, uz;
        ux = x;
        uy = y;
        uz = z;
        return {uz[CW-1:0], uy[CW-1:0], ux[CW-1:0]};
    endfunction

    function automatic int rand_coord(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic vtx_t rand_vertex(int span);
        return pack_vertex(rand_coord(span), rand_coord(span), rand_coord(span));
    endfunction

    // ray aimed at a weighted point of the triangle, mostly hits
    function automatic in_t aimed_ray(int span);
        in_t it;
        int a, b, c, sum, sh;
        int tx, ty, tz, ox, oy, oz;
        int p[3][3];
        for (int v = 0; v < 3; v++)
            for (int k = 0; k < 3; k++)
                p[v][k] = rand_coord(span);
        a = $urandom_range(0, 8);
        b = $urandom_range(0, 8);
        c = $urandom_range(0, 8);
        if (a + b + c == 0)
            a = 1;
        sum = a + b + c;
        tx = (a * p[0][0] + b * p[1][0] + c * p[2][0]) / sum;
        ty = (a * p[0][1] + b * p[1][1] + c * p[2][1]) / sum;
        tz = (a * p[0][2] + b * p[1][2] + c * p[2][2]) / sum;
        ox = rand_coord(span);
        oy = rand_coord(span);
        oz = rand_coord(span);
        // shortened direction pushes t up toward saturation
        sh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        it.vertex_zero   = pack_vertex(p[0][0], p[0][1], p[0][2]);
        it.vertex_one    = pack_vertex(p[1][0], p[1][1], p[1][2]);
        it.vertex_two    = pack_vertex(p[2][0], p[2][1], p[2][2]);
        it.ray_origin    = pack_vertex(ox, oy, oz);
        it.ray_direction = pack_vertex((tx - ox) >>> sh, (ty - oy) >>> sh, (tz - oz) >>> sh);
        if ($urandom_range(0, 9) < 7)
        begin
            it.t_lower = T_MIN;
            it.t_upper = T_MAX;
        end
        else
        begin
            it.t_lower = int'($urandom_range(0, 65536 * 4)) - 65536 * 2;
            it.t_upper = it.t_lower + int'($urandom_range(0, 65536 * 4)) - 65536;
        end
        return it;
    endfunction

    function automatic in_t random_item(int span);
        in_t it;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return aimed_ray(span);
        // raw noise over every bit
        it.vertex_zero   = 63'({$urandom, $urandom});
        it.vertex_one    = 63'({$urandom, $urandom});
        it.vertex_two    = 63'({$urandom, $urandom});
        it.ray_origin    = 63'({$urandom, $urandom});
        it.ray_direction = 63'({$urandom, $urandom});
        it.t_lower       = $urandom;
        it.t_upper       = $urandom;
        return it;
    endfunction

    function automatic in_t make_item(vtx_t v0, vtx_t v1, vtx_t v2, vtx_t o, vtx_t d,
                                      logic signed [31:0] tl, logic signed [31:0] tu);
        in_t it;
        it.vertex_zero   = v0;
        it.vertex_one    = v1;
        it.vertex_two    = v2;
        it.ray_origin    = o;
        it.ray_direction = d;
        it.t_lower       = tl;
        it.t_upper       = tu;
        return it;
    endfunction

    task automatic add_directed();
        vtx_t a, b, c, o, down, up;
        int big;
        big  = (1 << 20) - 1;
        a    = pack_vertex(0, 0, 0);
        b    = pack_vertex(1024, 0, 0);
        c    = pack_vertex(0, 1024, 0);
        o    = pack_vertex(256, 256, 1024);
        down = pack_vertex(0, 0, -1024);
        up   = pack_vertex(0, 0, 1024);
        // all zero: degenerate triangle
        pending_rays.push_back(make_item('0, '0, '0, '0, '0, '0, '0));
        // all ones everywhere
        pending_rays.push_back(make_item('1, '1, '1, '1, '1, '1, '1));
        // plain hit, t = 1
        pending_rays.push_back(make_item(a, b, c, o, down, T_MIN, T_MAX));
        // opposite winding, negative determinant
        pending_rays.push_back(make_item(a, c, b, o, down, T_MIN, T_MAX));
        // ray parallel to the plane
        pending_rays.push_back(make_item(a, b, c, o, pack_vertex(1024, 0, 0), T_MIN, T_MAX));
        // hit behind the origin, negative t
        pending_rays.push_back(make_item(a, b, c, o, up, T_MIN, T_MAX));
        // t outside the interval, then on both inclusive ends
        pending_rays.push_back(make_item(a, b, c, o, down, 0, 32'sh0000_8000));
        pending_rays.push_back(make_item(a, b, c, o, down, 32'sh0001_0000, 32'sh0001_0000));
        // empty interval
        pending_rays.push_back(make_item(a, b, c, o, down, 32'sh0002_0000, 32'sh0000_0000));
        // exactly on vertices and edges
        pending_rays.push_back(make_item(a, b, c, pack_vertex(1024, 0, 1024), down, T_MIN, T_MAX));
        pending_rays.push_back(make_item(a, b, c, pack_vertex(0, 1024, 1024), down, T_MIN, T_MAX));
        pending_rays.push_back(make_item(a, b, c, pack_vertex(512, 512, 1024), down, T_MIN, T_MAX));
        pending_rays.push_back(make_item(a, b, c, pack_vertex(0, 0, 1024), down, T_MIN, T_MAX));
        // just outside: b1 + b2 > 1 and b1 < 0
        pending_rays.push_back(make_item(a, b, c, pack_vertex(513, 512, 1024), down, T_MIN, T_MAX));
        pending_rays.push_back(make_item(a, b, c, pack_vertex(-1, 10, 1024), down, T_MIN, T_MAX));
        // saturating t both ways with the largest coordinates
        pending_rays.push_back(make_item(pack_vertex(-big, -big, 0), pack_vertex(big, -big, 0),
                                         pack_vertex(-big, big, 0), pack_vertex(0, 0, big),
                                         pack_vertex(0, 0, -1), T_MIN, T_MAX));
        pending_rays.push_back(make_item(pack_vertex(-big, -big, 0), pack_vertex(big, -big, 0),
                                         pack_vertex(-big, big, 0), pack_vertex(0, 0, big),
                                         pack_vertex(0, 0, 1), T_MIN, T_MAX));
        // most negative coordinates
        pending_rays.push_back(make_item(pack_vertex(-big - 1, -big - 1, -big - 1),
                                         pack_vertex(big, -big - 1, -big - 1),
                                         pack_vertex(-big - 1, big, -big - 1),
                                         pack_vertex(0, 0, big), pack_vertex(0, 0, -big - 1),
                                         T_MIN, T_MAX));
    endtask

    // wait at negedge until all transfers are done and every result is back
    task automatic wait_drained();
        @(negedge clk);
        while (pending_rays.size() != 0 || tri_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(int idle, int stall, int count, int span);
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int n = 0; n < count; n++)
            pending_rays.push_back(random_item(span));
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // driver: offers the next pending item once the current one is taken
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_valid <= 1'b0;
            tri_data  <= '0;
        end
        else
        begin
            // a transfer happens here, predict its result
            if (tri_valid && !tri_stall)
                expected_results.push_back(predict_intersection(tri_data));
            // payload only moves when not stalled
            if (!tri_valid || !tri_stall)
            begin
                if (pending_rays.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    tri_data  <= pending_rays.pop_front();
                    tri_valid <= 1'b1;
                end
                else
                    tri_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stalls plus one long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_request && !hold_done)
        begin
            hold_left <= 300;
            hold_done <= 1'b1;
            res_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ---------------------------------------------------------------
    // monitor: compares each result transfer with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", res_data);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_data.hit !== want.hit || res_data.distance !== want.distance
                    || res_data.bary_first !== want.bary_first
                    || res_data.bary_second !== want.bary_second
                    || res_data.hit_point !== want.hit_point
                    || res_data.ray_offset !== want.ray_offset)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %b %h %h %h %h %h, got %b %h %h %h %h %h",
                                 want.hit, want.distance, want.bary_first, want.bary_second,
                                 want.hit_point, want.ray_offset,
                                 res_data.hit, res_data.distance, res_data.bary_first,
                                 res_data.bary_second, res_data.hit_point, res_data.ray_offset);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        mismatches    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b0;
        rst_n         = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_directed();
        wait_drained();

        // small coordinates alternate with half-range spans up to 2^19 - 1
        run_phase(0, 0, 290, 4096);
        run_phase(79, 0, 290, (1 << 19) - 1);
        run_phase(0, 79, 290, 4096);
        run_phase(32, 32, 290, (1 << 19) - 1);

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        stall_pct     = 0;
        for (int n = 0; n < 290; n++)
            pending_rays.push_back(random_item(4096));
        hold_request = 1'b1;
        wait_drained();

        // pipeline latency plus margin
        repeat (60) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run time limit
    initial
    begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/rtid_pkg.sv
src/rtid_front.sv
src/rtid_div.sv
src/rtid_back.sv
src/ray_triangle_intersection_top.sv
verif/ray_triangle_intersection_top_test.sv
